@@ design/assert_macros.svh @@
// Assertion macros shared by the grid-step RTL modules.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_ON(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/lags_pkg.sv @@
// Shared sizes, codes and controller-to-datapath types for the life grid step.
// No dependencies; used by lags_ctrl, lags_dp and the top level.
`default_nettype none

package lags_pkg;

  // Grid geometry
  localparam int SIDE  = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int ROW_W = $clog2(SIDE);
  localparam int CNT_W = $clog2(CELLS + 1);

  localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(SIDE - 1);
  localparam logic [ROW_W-1:0] PRE_LAST = ROW_W'(SIDE - 2);

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_CELL,
    S_G_LOAD0,
    S_G_LOAD,
    S_G_CELL,
    S_G_WR,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             req_load;
    logic             rd_en;
    logic             rd_gen;
    logic [ROW_W-1:0] rd_row;
    logic             cell_op;
    logic             gen_init;
    logic             gen_load_cur;
    logic             gen_load_nxt;
    logic             nxt_zero;
    logic             gen_cell;
    logic             col_first;
    logic             col_last;
    logic             gen_wr;
    logic [ROW_W-1:0] wr_row;
    logic             gen_commit;
    logic             out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/life_automaton_grid_step_top.sv @@
// Top level of the life grid step: B3/S23 rule on a bounded square grid.
// Instantiates lags_ctrl and lags_dp; uses lags_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_req_type, in_row, in_col, in_cell_in
//   out_    | output    | out_valid/out_stall| out_cell_out, out_all_dead
//
// A write or read runs through the accept, cell and finish states to its result beat;
// an unused request skips the cell state. In a generation the rule unit evaluates one
// cell per cycle over rows rotated out of the two-port (read, write) row memory.
// Reset clears the per-row valid flags, so the grid reads all dead at once.
// One request is in flight at a time; a stalled result beat holds in the output
// register while the next request is accepted, and blocks only at its finish.
`default_nettype none

module life_automaton_grid_step_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [1:0] in_req_type,
  input  wire logic [5:0] in_row,
  input  wire logic [5:0] in_col,
  input  wire logic       in_cell_in,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_cell_out,
  output      logic       out_all_dead
);
  import lags_pkg::*;

  cmd_t cmd;
  req_t req_type;

  // Sequencing and handshake
  lags_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .req_type  (req_type),
    .cmd       (cmd)
  );

  // Grid storage and rule unit
  lags_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_req_type  (in_req_type),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_cell_in   (in_cell_in),
    .req_type     (req_type),
    .out_cell_out (out_cell_out),
    .out_all_dead (out_all_dead)
  );

endmodule

`default_nettype wire

@@ design/lags_dp.sv @@
// Datapath of the life grid step: row memory with row valid flags, request
// latch, three-row rule unit, live counter and result payload registers. Uses lags_pkg.
`default_nettype none

module lags_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lags_pkg::cmd_t      cmd,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [5:0]          in_row,
  input  wire logic [5:0]          in_col,
  input  wire logic                in_cell_in,
  output      lags_pkg::req_t      req_type,
  output      logic                out_cell_out,
  output      logic                out_all_dead
);
  import lags_pkg::*;

  `include "assert_macros.svh"

  // Request latch
  req_t             req_type_r;
  logic [ROW_W-1:0] req_row_r;
  logic [ROW_W-1:0] req_col_r;
  logic             cell_in_r;
  logic             inside_r;

  // Row memory
  logic [SIDE-1:0]  mem [SIDE];
  logic [SIDE-1:0]  row_vld_r;
  logic [SIDE-1:0]  rd_data_r;
  logic             rd_vld_r;
  logic [SIDE-1:0]  rdata;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [SIDE-1:0]  wr_data;
  logic [SIDE-1:0]  patched;

  // Rule unit
  logic [SIDE-1:0]  prev_r;
  logic [SIDE-1:0]  cur_r;
  logic [SIDE-1:0]  nxt_r;
  logic [SIDE-1:0]  new_row_r;
  logic [CNT_W-1:0] cnt_acc_r;
  logic [3:0]       nbr;
  logic             new_bit;
  logic [2:0]       lft;
  logic [2:0]       rgt;

  // Counter and result
  logic [CNT_W-1:0] live_count_r;
  logic             res_cell_r;
  logic             out_cell_out_r;
  logic             out_all_dead_r;
  logic             old_bit;
  logic             is_write;

  assign req_type = req_type_r;

  // Latch the request at acceptance
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type_r <= req_t'(in_req_type);
      req_row_r  <= ROW_W'(in_row);
      req_col_r  <= ROW_W'(in_col);
      cell_in_r  <= in_cell_in;
      inside_r   <= (32'(in_row) < 32'(SIDE)) && (32'(in_col) < 32'(SIDE));
    end
  end

  // Memory port selection
  assign rd_addr  = cmd.rd_gen ? cmd.rd_row : req_row_r;
  assign rdata    = rd_vld_r ? rd_data_r : '0;
  assign old_bit  = rdata[req_col_r];
  assign is_write = (req_type_r == REQ_WRITE) && inside_r;

  always_comb begin
    patched            = rdata;
    patched[req_col_r] = cell_in_r;
  end

  assign wr_en   = cmd.gen_wr || (cmd.cell_op && is_write);
  assign wr_addr = cmd.gen_wr ? cmd.wr_row : req_row_r;
  assign wr_data = cmd.gen_wr ? new_row_r : patched;

  // Write and read the row memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // Mark rows as written; an unmarked row reads as all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Neighbor window: left column at the top bit, right column at bit 1
  assign lft = cmd.col_first ? 3'b000 : {prev_r[SIDE-1], cur_r[SIDE-1], nxt_r[SIDE-1]};
  assign rgt = cmd.col_last  ? 3'b000 : {prev_r[1], cur_r[1], nxt_r[1]};

  always_comb begin
    nbr = 4'(lft[2]) + 4'(lft[1]) + 4'(lft[0]) + 4'(prev_r[0]) + 4'(nxt_r[0])
        + 4'(rgt[2]) + 4'(rgt[1]) + 4'(rgt[0]);
    if (cur_r[0]) begin
      new_bit = (nbr == 4'd2) || (nbr == 4'd3);
    end else begin
      new_bit = (nbr == 4'd3);
    end
  end

  // Rotate the three rows one column per cycle, assemble the new row
  always_ff @(posedge clk) begin
    if (cmd.gen_init) begin
      prev_r    <= '0;
      cnt_acc_r <= '0;
    end
    if (cmd.gen_load_cur) begin
      cur_r <= rdata;
    end
    if (cmd.gen_load_nxt) begin
      nxt_r <= cmd.nxt_zero ? '0 : rdata;
    end
    if (cmd.gen_cell) begin
      prev_r    <= {prev_r[0], prev_r[SIDE-1:1]};
      cur_r     <= {cur_r[0], cur_r[SIDE-1:1]};
      nxt_r     <= {nxt_r[0], nxt_r[SIDE-1:1]};
      new_row_r <= {new_bit, new_row_r[SIDE-1:1]};
      cnt_acc_r <= cnt_acc_r + CNT_W'(new_bit);
    end
    if (cmd.gen_wr) begin
      prev_r <= cur_r;
      cur_r  <= nxt_r;
    end
  end

  // Track the number of live cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_count_r <= '0;
    end else if (cmd.gen_commit) begin
      live_count_r <= cnt_acc_r;
    end else if (cmd.cell_op && is_write && (old_bit != cell_in_r)) begin
      if (cell_in_r) begin
        live_count_r <= live_count_r + CNT_W'(1);
      end else begin
        live_count_r <= live_count_r - CNT_W'(1);
      end
    end
  end

  // Hold the read result until the beat is loaded
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      res_cell_r <= 1'b0;
    end else if (cmd.cell_op) begin
      res_cell_r <= (req_type_r == REQ_READ) && inside_r && old_bit;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_out_r <= res_cell_r;
      out_all_dead_r <= (live_count_r == '0);
    end
  end

  assign out_cell_out = out_cell_out_r;
  assign out_all_dead = out_all_dead_r;

  `ASSERT_ON(a_live_in_range, live_count_r <= CNT_W'(CELLS), "live count beyond grid size")
  `ASSERT_ON(a_no_rw_clash, (wr_en && cmd.rd_en) |-> (wr_addr != rd_addr),
    "row read and written in the same cycle")

endmodule

`default_nettype wire

@@ design/lags_ctrl.sv @@
// Controller of the life grid step: request sequencing, row and column
// sweep counters, input stall and output valid. Uses lags_pkg.
`default_nettype none

module lags_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_stall,
  output      logic           out_valid,
  input  wire logic           out_stall,
  input  wire lags_pkg::req_t req_type,
  output      lags_pkg::cmd_t cmd
);
  import lags_pkg::*;

  `include "assert_macros.svh"

  state_t           state_r;
  state_t           state_nxt;
  logic [ROW_W-1:0] row_cnt_r;
  logic [ROW_W-1:0] row_cnt_nxt;
  logic [ROW_W-1:0] col_r;
  logic [ROW_W-1:0] col_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_ACC;
      end
      S_ACC: begin
        case (req_type)
          REQ_WRITE: state_nxt = S_CELL;
          REQ_READ:  state_nxt = S_CELL;
          REQ_STEP:  state_nxt = S_G_LOAD0;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_CELL:    state_nxt = S_DONE;
      S_G_LOAD0: state_nxt = S_G_LOAD;
      S_G_LOAD:  state_nxt = S_G_CELL;
      S_G_CELL: begin
        if (col_r == LAST_IDX) state_nxt = S_G_WR;
      end
      S_G_WR: begin
        state_nxt = (row_cnt_r == LAST_IDX) ? S_DONE : S_G_LOAD;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sweep counters
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_nxt     = col_r;
    case (state_r)
      S_ACC:    row_cnt_nxt = '0;
      S_G_LOAD: col_nxt     = '0;
      S_G_CELL: col_nxt     = col_r + ROW_W'(1);
      S_G_WR:   row_cnt_nxt = row_cnt_r + ROW_W'(1);
      default: begin
      end
    endcase
  end

  // Output valid: set when the result is loaded, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.rd_row   = '0;
    cmd.wr_row   = row_cnt_r;
    case (state_r)
      S_IDLE: begin
        cmd.req_load = accept;
      end
      S_ACC: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_gen   = (req_type == REQ_STEP);
        cmd.gen_init = (req_type == REQ_STEP);
      end
      S_CELL: begin
        cmd.cell_op = 1'b1;
      end
      S_G_LOAD0: begin
        cmd.gen_load_cur = 1'b1;
        cmd.rd_en        = 1'b1;
        cmd.rd_gen       = 1'b1;
        cmd.rd_row       = ROW_W'(1);
      end
      S_G_LOAD: begin
        cmd.gen_load_nxt = 1'b1;
        cmd.nxt_zero     = (row_cnt_r == LAST_IDX);
      end
      S_G_CELL: begin
        cmd.gen_cell  = 1'b1;
        cmd.col_first = (col_r == '0);
        cmd.col_last  = (col_r == LAST_IDX);
      end
      S_G_WR: begin
        cmd.gen_wr     = 1'b1;
        cmd.gen_commit = (row_cnt_r == LAST_IDX);
        cmd.rd_en      = (row_cnt_r < PRE_LAST);
        cmd.rd_gen     = 1'b1;
        cmd.rd_row     = row_cnt_r + ROW_W'(2);
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_cnt_r   <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_ON(a_accept_starts, accept |=> (state_r == S_ACC),
    "accepted beat did not start a request")
  `ASSERT_ON(a_row_end, (state_r == S_G_CELL && col_r == LAST_IDX) |=> (state_r == S_G_WR),
    "row sweep did not end in a row write")
  `ASSERT_ON(a_valid_from_done, $rose(out_valid_r) |-> ($past(state_r) == S_DONE),
    "result beat raised outside the finish state")

endmodule

`default_nettype wire
